/* sv/vpa_pkg.sv */
// Shared types and constants of the variable partition allocator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package vpa_pkg;

    localparam int HOLES     = 32;
    localparam int IDX_W     = $clog2(HOLES);
    localparam int CNT_W     = $clog2(HOLES + 1);
    localparam int ADDR_W    = 16;
    localparam logic [ADDR_W-1:0] MEM_RESET = 16'd2000;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } t_fit_mode;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_FIT_MODE = 1'b0;
    localparam logic CFG_MEM_SIZE = 1'b1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_REM,
        S_FSRCH,
        S_INS
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
    } t_hole;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_hole            data;
    } t_tbl_wr;

endpackage
`default_nettype wire

/* sv/vpa_hole_table.sv */
// Hole table: flip-flop storage of hole start and length, one write and one read port.
// Depends on vpa_pkg.
`default_nettype none
module vpa_hole_table
    import vpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_tbl_wr           i_wr,
    input  wire logic [IDX_W-1:0]  i_rd_addr,
    output t_hole                  o_rd
);

    t_hole r_tab [HOLES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tab[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd = r_tab[i_rd_addr];

endmodule
`default_nettype wire

/* sv/vpa_seq.sv */
// Sequencer and shared compare/add unit that scans, shifts and updates the hole table.
// Depends on vpa_pkg and drives the ports of vpa_hole_table.
`default_nettype none
module vpa_seq
    import vpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_init,
    input  wire t_fit_mode         i_fit_mode,
    input  wire logic [ADDR_W-1:0] i_mem_size,
    input  wire logic              i_start,
    input  wire logic              i_kind,
    input  wire logic [ADDR_W-1:0] i_size,
    input  wire logic [ADDR_W-1:0] i_fbase,
    output logic                   o_busy,
    output logic                   o_valid,
    output t_status                o_status,
    output logic [ADDR_W-1:0]      o_base,
    output logic [IDX_W-1:0]       o_rd_addr,
    output t_tbl_wr                o_wr,
    input  wire t_hole             i_rd
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_size, n_size, r_fbase, n_fbase;
    logic [CNT_W-1:0]  r_idx, n_idx, r_k, n_k, r_count, n_count, r_p, n_p;
    logic [IDX_W-1:0]  r_pick, n_pick, r_nfi, n_nfi;
    logic              r_found, n_found, r_have_prev, n_have_prev, r_from_alloc, n_from_alloc;
    logic [ADDR_W-1:0] r_best, n_best, r_prev_start, n_prev_start, r_prev_len, n_prev_len;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_base, n_base;

    logic [CNT_W-1:0]  idx_p1, idx_m1, cnt_m1;
    logic [ADDR_W:0]   f_end, prev_end;
    logic              fits, take, in_tab, jp, jn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_valid <= 1'b0;
            r_count <= '0;
            r_nfi   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            r_nfi   <= n_nfi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_fbase      <= n_fbase;
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_p          <= n_p;
        r_pick       <= n_pick;
        r_found      <= n_found;
        r_have_prev  <= n_have_prev;
        r_from_alloc <= n_from_alloc;
        r_best       <= n_best;
        r_prev_start <= n_prev_start;
        r_prev_len   <= n_prev_len;
        r_status     <= n_status;
        r_base       <= n_base;
    end

    assign idx_p1   = r_idx + CNT_W'(1);
    assign idx_m1   = r_idx - CNT_W'(1);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign f_end    = {1'b0, r_fbase} + {1'b0, r_size};
    assign prev_end = {1'b0, r_prev_start} + {1'b0, r_prev_len};
    assign fits     = i_rd.len >= r_size;
    assign in_tab   = r_idx < r_count;
    assign jp       = r_have_prev && (prev_end == {1'b0, r_fbase});
    assign jn       = in_tab && ({1'b0, i_rd.start} == f_end);
    assign take     = (i_fit_mode == FIT_BEST) ? (fits && (!r_found || i_rd.len < r_best))
                                               : (!r_found || i_rd.len > r_best);

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_fbase      = r_fbase;
        n_idx        = r_idx;
        n_k          = r_k;
        n_p          = r_p;
        n_pick       = r_pick;
        n_found      = r_found;
        n_have_prev  = r_have_prev;
        n_from_alloc = r_from_alloc;
        n_best       = r_best;
        n_prev_start = r_prev_start;
        n_prev_len   = r_prev_len;
        n_count      = r_count;
        n_nfi        = r_nfi;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_base       = r_base;
        o_rd_addr    = r_idx[IDX_W-1:0];
        o_wr         = '0;

        unique case (r_state)
            S_INIT: begin
                o_wr.en   = 1'b1;
                o_wr.addr = '0;
                o_wr.data = '{start: '0, len: i_mem_size};
                n_count   = (i_mem_size != '0) ? CNT_W'(1) : '0;
                n_nfi     = '0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_size  = i_size;
                    n_fbase = i_fbase;
                    n_base  = '0;
                    n_idx   = '0;
                    n_k     = '0;
                    n_found = 1'b0;
                    n_have_prev = 1'b0;
                    if (i_kind == KIND_ALLOC) begin
                        if (i_size == '0 || r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_NOFIT;
                        end else begin
                            if (i_fit_mode == FIT_NEXT && {1'b0, r_nfi} < r_count) begin
                                n_idx = {1'b0, r_nfi};
                            end
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_size == '0) begin
                            n_valid  = 1'b1;
                            n_status = ST_DONE;
                        end else if (({1'b0, i_fbase} + {1'b0, i_size}) > {1'b0, i_mem_size}) begin
                            n_valid  = 1'b1;
                            n_status = ST_NOFIT;
                        end else begin
                            n_state = S_FSRCH;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_fit_mode == FIT_FIRST || i_fit_mode == FIT_NEXT) begin
                    if (fits) begin
                        n_pick  = r_idx[IDX_W-1:0];
                        n_state = S_PLACE;
                    end else if (r_k == cnt_m1) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOFIT;
                        n_state  = S_IDLE;
                    end else begin
                        n_k   = r_k + CNT_W'(1);
                        n_idx = (idx_p1 == r_count) ? '0 : idx_p1;
                    end
                end else begin
                    if (take) begin
                        n_pick  = r_idx[IDX_W-1:0];
                        n_best  = i_rd.len;
                        n_found = 1'b1;
                    end
                    if (r_idx == cnt_m1) begin
                        if ((i_fit_mode == FIT_BEST) ? (take || r_found)
                                                     : (take ? fits : (r_best >= r_size))) begin
                            n_state = S_PLACE;
                        end else begin
                            n_valid  = 1'b1;
                            n_status = ST_NOFIT;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        n_idx = idx_p1;
                    end
                end
            end
            S_PLACE: begin
                o_rd_addr = r_pick;
                o_wr.en   = 1'b1;
                o_wr.addr = r_pick;
                o_wr.data = '{start: i_rd.start + r_size, len: i_rd.len - r_size};
                n_base    = i_rd.start;
                if (i_rd.len == r_size) begin
                    n_idx        = {1'b0, r_pick};
                    n_from_alloc = 1'b1;
                    n_state      = S_REM;
                end else begin
                    n_nfi    = r_pick;
                    n_valid  = 1'b1;
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                end
            end
            S_REM: begin
                if (idx_p1 < r_count) begin
                    o_rd_addr = idx_p1[IDX_W-1:0];
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_idx[IDX_W-1:0];
                    o_wr.data = i_rd;
                    n_idx     = idx_p1;
                end else begin
                    n_count = cnt_m1;
                    if (r_from_alloc) begin
                        n_nfi = ({1'b0, r_pick} < cnt_m1) ? r_pick : '0;
                    end
                    n_valid  = 1'b1;
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                end
            end
            S_FSRCH: begin
                if (in_tab && i_rd.start < r_fbase) begin
                    n_prev_start = i_rd.start;
                    n_prev_len   = i_rd.len;
                    n_have_prev  = 1'b1;
                    n_idx        = idx_p1;
                end else if ((r_have_prev && prev_end > {1'b0, r_fbase})
                             || (in_tab && {1'b0, i_rd.start} < f_end)) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOFIT;
                    n_state  = S_IDLE;
                end else if (jp) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = idx_m1[IDX_W-1:0];
                    o_wr.data = '{start: r_prev_start,
                                  len: r_prev_len + r_size + (jn ? i_rd.len : '0)};
                    if (jn) begin
                        n_from_alloc = 1'b0;
                        n_state      = S_REM;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ST_DONE;
                        n_state  = S_IDLE;
                    end
                end else if (jn) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_idx[IDX_W-1:0];
                    o_wr.data = '{start: r_fbase, len: i_rd.len + r_size};
                    n_valid   = 1'b1;
                    n_status  = ST_DONE;
                    n_state   = S_IDLE;
                end else if (r_count >= CNT_W'(HOLES)) begin
                    n_valid  = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_p     = r_idx;
                    n_idx   = r_count;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (r_idx > r_p) begin
                    o_rd_addr = idx_m1[IDX_W-1:0];
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_idx[IDX_W-1:0];
                    o_wr.data = i_rd;
                    n_idx     = idx_m1;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_p[IDX_W-1:0];
                    o_wr.data = '{start: r_fbase, len: r_size};
                    n_count   = r_count + CNT_W'(1);
                    n_valid   = 1'b1;
                    n_status  = ST_DONE;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase

        if (i_init) begin
            n_state = S_INIT;
        end
    end

    // A pending table rebuild holds off new requests as well.
    assign o_busy   = (r_state != S_IDLE) || i_init;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_base   = r_base;

endmodule
`default_nettype wire

/* sv/variable_partition_allocator.sv */
// Variable partition allocator: a sorted free-hole table with first, best, worst and next fit.
// Operation: an allocate scans the holes, places the block in the chosen hole and, on an exact
// fit, shifts the entries above it down; a free walks the holes below its base and then
// merges with its neighbours (shifting entries down when it joins both) or inserts a new
// hole, shifting entries up. One request is in progress at a time; the receiver
// cannot stall, each result is strobed for one cycle. Reset is synchronous; the block loads
// the initial hole in its init state before it is ready, and again after a memory size write.
// Depends on vpa_pkg, vpa_seq and vpa_hole_table.
`default_nettype none
module variable_partition_allocator
    import vpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_kind,
    input  wire logic [ADDR_W-1:0] i_request_size,
    input  wire logic [ADDR_W-1:0] i_free_base,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [ADDR_W-1:0]      o_base_address,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data
);

    // Configuration registers. A write of the memory size also asks the sequencer to
    // rebuild the table as a single hole covering the new size, or as an empty table for size zero.
    t_fit_mode         r_fit_mode;
    logic [ADDR_W-1:0] r_mem_size;
    logic              r_init;

    logic              cfg_we;
    t_status           status;
    logic [IDX_W-1:0]  rd_addr;
    t_tbl_wr           wr;
    t_hole             rd;

    // The configuration channel is always able to take a transfer.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_FIRST;
            r_mem_size <= MEM_RESET;
            r_init     <= 1'b0;
        end else begin
            r_init <= cfg_we && (i_cfg_index == CFG_MEM_SIZE);
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIT_MODE: r_fit_mode <= t_fit_mode'(i_cfg_data[1:0]);
                    CFG_MEM_SIZE: r_mem_size <= i_cfg_data;
                    default:      r_mem_size <= r_mem_size;
                endcase
            end
        end
    end

    // The sequencer walks the table one entry per cycle through the single read port.
    vpa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (r_init),
        .i_fit_mode (r_fit_mode),
        .i_mem_size (r_mem_size),
        .i_start    (start && !busy),
        .i_kind     (i_kind),
        .i_size     (i_request_size),
        .i_fbase    (i_free_base),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_status   (status),
        .o_base     (o_base_address),
        .o_rd_addr  (rd_addr),
        .o_wr       (wr),
        .i_rd       (rd)
    );

    vpa_hole_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    assign o_status = status;

endmodule
`default_nettype wire
